>>> hw/rtl/lzw_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the lzw compressor core
// no dependencies; compiled before the interfaces and modules
package lzw_pkg;

   localparam int DEF_HASH_SLOTS = 8192;
   localparam int DEF_CODE_BITS  = 12;

   localparam int BYTE_BITS  = 8;
   localparam int LIMIT_BITS = 13;
   localparam int EPOCH_BITS = 4;

   localparam logic [LIMIT_BITS-1:0] DICT_LIMIT_RESET = 13'd4096;
   localparam int FIRST_FREE_CODE = 256;

   // multiplicative hash constant (golden ratio)
   localparam logic [31:0] HASH_MULT = 32'd2654435761;
   localparam int HASH_SHIFT = 8;

   localparam logic [EPOCH_BITS-1:0] EPOCH_CLEARED = '0;
   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST   = 4'd1;
   localparam logic [EPOCH_BITS-1:0] EPOCH_MAX     = '1;

   // dictionary port commands
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } lzw_dict_ctl_type;

   // outcome of one probe of the dictionary
   typedef struct packed {
      logic empty;
      logic hit;
   } lzw_probe_type;

endpackage

>>> hw/rtl/lzw_req_if.sv
`timescale 1ns / 1ps
// input channel of the lzw compressor: one byte and an end-of-stream mark
// depends on lzw_pkg
interface lzw_req_if import lzw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;
   logic                 end_of_stream;

   modport source(output valid, output data_byte, output end_of_stream, input ready);
   modport sink(input valid, input data_byte, input end_of_stream, output ready);
endinterface

>>> hw/rtl/lzw_rsp_if.sv
`timescale 1ns / 1ps
// result channel of the lzw compressor: one code and a last mark
// depends on lzw_pkg
interface lzw_rsp_if import lzw_pkg::*; #(
   parameter int CODE_BITS = DEF_CODE_BITS
) ();
   logic                 valid;
   logic                 ready;
   logic [CODE_BITS-1:0] code;
   logic                 last_code;

   modport source(output valid, output code, output last_code, input ready);
   modport sink(input valid, input code, input last_code, output ready);
endinterface

>>> hw/rtl/lzw_hash.sv
`timescale 1ns / 1ps
// multiplicative hash of (prefix code, byte) to a home slot, one registered multiply
// depends on lzw_pkg
module lzw_hash import lzw_pkg::*; #(
   parameter int CODE_BITS  = DEF_CODE_BITS,
   parameter int HASH_SLOTS = DEF_HASH_SLOTS
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [CODE_BITS-1:0]          prefix,
   input  logic [BYTE_BITS-1:0]          data_byte,
   output logic [$clog2(HASH_SLOTS)-1:0] slot
);
   localparam int SLOT_BITS = $clog2(HASH_SLOTS);
   localparam int KEY_BITS  = CODE_BITS + BYTE_BITS;

   logic [KEY_BITS-1:0] key;
   logic [31:0]         product_in;
   logic [31:0]         product_ff;

   assign key        = {prefix, data_byte};
   assign product_in = 32'(32'(key) * HASH_MULT);

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   // shift right, then keep the slot bits (slot count is a power of two)
   assign slot = product_ff[HASH_SHIFT +: SLOT_BITS];

endmodule

>>> hw/rtl/lzw_dict.sv
`timescale 1ns / 1ps
// hashed dictionary memory with registered read and entry compare
// depends on lzw_pkg
module lzw_dict import lzw_pkg::*; #(
   parameter int CODE_BITS  = DEF_CODE_BITS,
   parameter int HASH_SLOTS = DEF_HASH_SLOTS
) (
   input  logic                          clock,
   input  lzw_dict_ctl_type              ctl,
   input  logic [$clog2(HASH_SLOTS)-1:0] addr,
   input  logic [EPOCH_BITS-1:0]         wr_tag,
   input  logic [CODE_BITS-1:0]          wr_prefix,
   input  logic [BYTE_BITS-1:0]          wr_byte,
   input  logic [CODE_BITS-1:0]          wr_code,
   input  logic [EPOCH_BITS-1:0]         epoch,
   input  logic [CODE_BITS-1:0]          key_prefix,
   input  logic [BYTE_BITS-1:0]          key_byte,
   output lzw_probe_type                 probe,
   output logic [CODE_BITS-1:0]          hit_code
);
   localparam int ENTRY_BITS = EPOCH_BITS + CODE_BITS + BYTE_BITS + CODE_BITS;

   logic [ENTRY_BITS-1:0] mem [HASH_SLOTS];
   logic [ENTRY_BITS-1:0] rd_data_ff;

   logic [EPOCH_BITS-1:0] rd_tag;
   logic [CODE_BITS-1:0]  rd_prefix;
   logic [BYTE_BITS-1:0]  rd_byte;
   logic                  rd_live;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= {wr_tag, wr_prefix, wr_byte, wr_code};
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign {rd_tag, rd_prefix, rd_byte, hit_code} = rd_data_ff;

   // an entry is live only if written during the current epoch
   assign rd_live     = (rd_tag == epoch);
   assign probe.empty = !rd_live;
   assign probe.hit   = rd_live && (rd_prefix == key_prefix) && (rd_byte == key_byte);

endmodule

>>> hw/rtl/lzw_compressor_core.sv
`timescale 1ns / 1ps
// lzw compressor top level: sequencer, stream state and result register
// depends on lzw_pkg, lzw_req_if, lzw_rsp_if, lzw_hash, lzw_dict
//
// usage
//  req_if carries one byte per item plus an end-of-stream mark; rsp_if returns
//  lzw codes, the final code of a stream flagged with last_code
//  csr_wr_en/csr_wr_data set the dictionary limit; write only while idle
//  the first byte of a stream produces no code unless it also ends the stream
//  an item gives zero, one or two codes (a miss code, then the final code)
// sequence
//  an item reaching the dictionary is accepted, hashed, read and compared;
//  each collision probe repeats read and compare; all work goes through
//  the one dictionary port, so req_if.ready is low until the item is finished
//  a stream's first byte needs no probe; an end of stream adds the last step
// reset and clearing
//  after reset the dictionary memory is swept before the first item is taken;
//  entries carry an epoch tag so ending a stream forgets the dictionary at
//  once, and every 15th stream end repeats the sweep
// back-pressure
//  results sit in one output register; the next item is still accepted while
//  it waits, and the sequencer holds only when it has a code to hand over
//  and the register is still full
// HASH_SLOTS must be a power of two
module lzw_compressor_core import lzw_pkg::*; #(
   parameter int HASH_SLOTS = DEF_HASH_SLOTS,
   parameter int CODE_BITS  = DEF_CODE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   lzw_req_if.sink               req_if,
   lzw_rsp_if.source             rsp_if,
   input  logic                  csr_wr_en,
   input  logic [LIMIT_BITS-1:0] csr_wr_data
);
   localparam int SLOT_BITS = $clog2(HASH_SLOTS);
   localparam int NEXT_BITS = CODE_BITS + 1;
   localparam int CMP_BITS  = (NEXT_BITS > LIMIT_BITS) ? NEXT_BITS : LIMIT_BITS;
   localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(HASH_SLOTS - 1);
   localparam logic [NEXT_BITS-1:0] NEXT_FIRST = NEXT_BITS'(FIRST_FREE_CODE);
   localparam logic [CMP_BITS-1:0]  CODE_SPACE = CMP_BITS'(1) << CODE_BITS;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_HASH  = 6'b000100,
      ST_PROBE = 6'b001000,
      ST_CHECK = 6'b010000,
      ST_LAST  = 6'b100000
   } lzw_state_type;

   // sequencer and stream state
   lzw_state_type          state_ff, state_in;
   logic [CODE_BITS-1:0]   current_code_ff, current_code_in;
   logic                   have_current_ff, have_current_in;
   logic [NEXT_BITS-1:0]   next_code_ff, next_code_in;
   logic [LIMIT_BITS-1:0]  dict_limit_ff, dict_limit_in;
   logic [EPOCH_BITS-1:0]  epoch_ff, epoch_in;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;
   logic [SLOT_BITS-1:0]   probe_cnt_ff, probe_cnt_in;

   // latched item
   logic [BYTE_BITS-1:0]   byte_ff, byte_in;
   logic                   eos_ff, eos_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CODE_BITS-1:0]   rsp_code_ff, rsp_code_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   req_accept;
   logic                   out_free;
   logic                   rsp_load;
   logic                   hash_load;
   logic [SLOT_BITS-1:0]   hash_slot;
   lzw_dict_ctl_type       dict_ctl;
   logic [EPOCH_BITS-1:0]  dict_wr_tag;
   lzw_probe_type          probe;
   logic [CODE_BITS-1:0]   hit_code;
   logic [CMP_BITS-1:0]    limit_ext;
   logic [CMP_BITS-1:0]    limit_use;
   logic                   may_learn;
   logic [CODE_BITS-1:0]   byte_code;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.code      = rsp_code_ff;
   assign rsp_if.last_code = rsp_last_ff;

   // limit in use is the smaller of the register and the code space
   assign limit_ext = CMP_BITS'(dict_limit_ff);
   assign limit_use = (limit_ext < CODE_SPACE) ? limit_ext : CODE_SPACE;
   assign may_learn = (CMP_BITS'(next_code_ff) < limit_use);
   assign byte_code = {{(CODE_BITS - BYTE_BITS){1'b0}}, byte_ff};

   lzw_hash #(
      .CODE_BITS  (CODE_BITS),
      .HASH_SLOTS (HASH_SLOTS)
   ) u_hash (
      .clock     (clock),
      .load      (hash_load),
      .prefix    (current_code_ff),
      .data_byte (req_if.data_byte),
      .slot      (hash_slot)
   );

   lzw_dict #(
      .CODE_BITS  (CODE_BITS),
      .HASH_SLOTS (HASH_SLOTS)
   ) u_dict (
      .clock      (clock),
      .ctl        (dict_ctl),
      .addr       (slot_ff),
      .wr_tag     (dict_wr_tag),
      .wr_prefix  (current_code_ff),
      .wr_byte    (byte_ff),
      .wr_code    (next_code_ff[CODE_BITS-1:0]),
      .epoch      (epoch_ff),
      .key_prefix (current_code_ff),
      .key_byte   (byte_ff),
      .probe      (probe),
      .hit_code   (hit_code)
   );

   always_comb begin
      state_in        = state_ff;
      current_code_in = current_code_ff;
      have_current_in = have_current_ff;
      next_code_in    = next_code_ff;
      dict_limit_in   = dict_limit_ff;
      epoch_in        = epoch_ff;
      slot_in         = slot_ff;
      probe_cnt_in    = probe_cnt_ff;
      byte_in         = byte_ff;
      eos_in          = eos_ff;
      rsp_code_in     = rsp_code_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_load        = 1'b0;
      hash_load       = 1'b0;
      dict_ctl        = '0;
      dict_wr_tag     = epoch_ff;

      // configuration is taken in any state
      if (csr_wr_en) begin
         dict_limit_in = csr_wr_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            // sweep: retag every slot as never written
            dict_ctl.wr_en = 1'b1;
            dict_wr_tag    = EPOCH_CLEARED;
            slot_in        = slot_ff + SLOT_BITS'(1);
            if (slot_ff == SLOT_LAST) begin
               epoch_in = EPOCH_FIRST;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               byte_in = req_if.data_byte;
               eos_in  = req_if.end_of_stream;
               if (!have_current_ff) begin
                  // first byte of a stream opens the match
                  current_code_in = {{(CODE_BITS - BYTE_BITS){1'b0}}, req_if.data_byte};
                  have_current_in = 1'b1;
                  if (req_if.end_of_stream) begin
                     state_in = ST_LAST;
                  end
               end else begin
                  hash_load = 1'b1;
                  state_in  = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            slot_in      = hash_slot;
            probe_cnt_in = '0;
            state_in     = ST_PROBE;
         end
         ST_PROBE: begin
            dict_ctl.rd_en = 1'b1;
            state_in       = ST_CHECK;
         end
         ST_CHECK: begin
            if (probe.hit) begin
               // match grows
               current_code_in = hit_code;
               state_in        = eos_ff ? ST_LAST : ST_IDLE;
            end else if (probe.empty || (probe_cnt_ff == SLOT_LAST)) begin
               // miss, or a full table after a complete sweep of probes
               if (out_free) begin
                  rsp_load    = 1'b1;
                  rsp_code_in = current_code_ff;
                  rsp_last_in = 1'b0;
                  if (may_learn && probe.empty) begin
                     dict_ctl.wr_en = 1'b1;
                     next_code_in   = next_code_ff + NEXT_BITS'(1);
                  end
                  current_code_in = byte_code;
                  state_in        = eos_ff ? ST_LAST : ST_IDLE;
               end
            end else begin
               // collision: linear probe to the next slot
               slot_in      = slot_ff + SLOT_BITS'(1);
               probe_cnt_in = probe_cnt_ff + SLOT_BITS'(1);
               state_in     = ST_PROBE;
            end
         end
         ST_LAST: begin
            if (out_free) begin
               rsp_load        = 1'b1;
               rsp_code_in     = current_code_ff;
               rsp_last_in     = 1'b1;
               current_code_in = '0;
               have_current_in = 1'b0;
               next_code_in    = NEXT_FIRST;
               // new epoch forgets the dictionary; out of epochs means a sweep
               if (epoch_ff == EPOCH_MAX) begin
                  slot_in  = '0;
                  state_in = ST_CLEAR;
               end else begin
                  epoch_in = epoch_ff + EPOCH_BITS'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         current_code_ff <= '0;
         have_current_ff <= 1'b0;
         next_code_ff    <= NEXT_FIRST;
         dict_limit_ff   <= DICT_LIMIT_RESET;
         epoch_ff        <= EPOCH_CLEARED;
         slot_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         current_code_ff <= current_code_in;
         have_current_ff <= have_current_in;
         next_code_ff    <= next_code_in;
         dict_limit_ff   <= dict_limit_in;
         epoch_ff        <= epoch_in;
         slot_ff         <= slot_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      probe_cnt_ff <= probe_cnt_in;
      byte_ff      <= byte_in;
      eos_ff       <= eos_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_last_ff  <= rsp_last_in;
   end

`ifndef SYNTHESIS
   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset) rsp_load |-> out_free)
      else $error("result register loaded while still full");

   // the single dictionary port never reads and writes together
   assert property (@(posedge clock) disable iff (reset) !(dict_ctl.rd_en && dict_ctl.wr_en))
      else $error("dictionary read and write in the same cycle");

   // items are only taken once the sweep has set a live epoch
   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (epoch_ff != EPOCH_CLEARED))
      else $error("item accepted before dictionary sweep finished");

   // next code advances by one or returns to the first free code
   assert property (@(posedge clock) disable iff (reset)
      (next_code_ff != $past(next_code_ff)) |->
      ((next_code_ff == $past(next_code_ff) + NEXT_BITS'(1)) || (next_code_ff == NEXT_FIRST)))
      else $error("next code jumped");

   // a learned entry is only written after a probe found a free slot
   assert property (@(posedge clock) disable iff (reset)
      (dict_ctl.wr_en && (state_ff == ST_CHECK)) |-> (probe.empty && may_learn))
      else $error("dictionary write without a free slot");
`endif

endmodule

>>> tb/lzw_compressor_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for lzw_compressor_core: a directed table, then random byte streams
// depends on lzw_pkg, lzw_req_if, lzw_rsp_if and the core; codes come from a dictionary model or the table
module lzw_compressor_core_tb;
   import lzw_pkg::*;

   localparam int HASH_SLOTS   = DEF_HASH_SLOTS;
   localparam int CODE_BITS    = DEF_CODE_BITS;
   localparam int CODE_SPACE   = 1 << CODE_BITS;
   localparam int IDLE_LIMIT   = 50000;  // well above the dictionary sweep after reset
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD    = 300;
   localparam int PHASE_ITEMS  = 70;
   localparam int NUM_PHASES   = 8;
   localparam int NUM_ROWS     = 27;

   typedef logic [CODE_BITS-1:0] code_type;

   typedef struct packed {
      code_type code;
      logic     last_code;
   } code_item_type;

   typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [LIMIT_BITS-1:0] limit;
      logic [BYTE_BITS-1:0]  data;
      logic                  eos;
      logic                  typed;
      logic [1:0]            n_codes;
      code_type              code_a;
      logic                  last_a;
      code_type              code_b;
      logic                  last_b;
   } dir_row_type;

   typedef enum int {MIX_NARROW, MIX_FULL, MIX_RUN} stream_mix_type;

   // kind, limit, byte, eos, typed, count, first code, last, second code, last
   localparam dir_row_type DIRECTED [NUM_ROWS] = '{
      '{ROW_ITEM,  13'd0,    8'h00, 1'b1, 1'b1, 2'd1, 12'h000, 1'b1, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'hFF, 1'b1, 1'b1, 2'd1, 12'h0FF, 1'b1, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h41, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h42, 1'b1, 1'b1, 2'd2, 12'h041, 1'b0, 12'h042, 1'b1},
      '{ROW_ITEM,  13'd0,    8'h41, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h41, 1'b0, 1'b1, 2'd1, 12'h041, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h41, 1'b1, 1'b1, 2'd1, 12'd256, 1'b1, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h00, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h00, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h00, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h00, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h00, 1'b1, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_LIMIT, 13'd256,  8'h00, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h7F, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h7F, 1'b0, 1'b1, 2'd1, 12'h07F, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h7F, 1'b1, 1'b1, 2'd2, 12'h07F, 1'b0, 12'h07F, 1'b1},
      '{ROW_LIMIT, 13'd0,    8'h00, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h80, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h80, 1'b1, 1'b1, 2'd2, 12'h080, 1'b0, 12'h080, 1'b1},
      '{ROW_LIMIT, 13'd257,  8'h00, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h55, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h55, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h55, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h55, 1'b1, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_LIMIT, 13'd8191, 8'h00, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'hC3, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
      '{ROW_ITEM,  13'd0,    8'h3C, 1'b1, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [LIMIT_BITS-1:0] csr_wr_data;

   lzw_req_if                           req_if ();
   lzw_rsp_if #(.CODE_BITS(CODE_BITS))  rsp_if ();

   lzw_compressor_core #(
      .HASH_SLOTS(HASH_SLOTS),
      .CODE_BITS (CODE_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // dictionary model: (prefix code, byte) -> code, open addressing
   bit                    slot_used   [HASH_SLOTS];
   code_type              slot_prefix [HASH_SLOTS];
   logic [BYTE_BITS-1:0]  slot_byte   [HASH_SLOTS];
   code_type              slot_code   [HASH_SLOTS];
   code_type              match_code;
   bit                    match_open;
   logic [LIMIT_BITS-1:0] next_free;
   logic [LIMIT_BITS-1:0] limit_reg;
   code_item_type         pending_codes [$];

   // what the sender tells the checker about the item on offer
   bit            offer_typed;
   int            offer_typed_n;
   code_item_type offer_code_a;
   code_item_type offer_code_b;

   int  sender_idle_pct;
   int  rcv_stall_pct;
   bit  long_hold_req;
   int  err_count;
   int  items_taken;
   int  codes_seen;
   int  streams_sent;
   int  limit_writes;
   int  long_holds;
   int  quiet_cycles;

   function automatic void forget_dictionary();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      match_code = '0;
      match_open = 1'b0;
      next_free  = LIMIT_BITS'(FIRST_FREE_CODE);
   endfunction

   function automatic int home_slot(input code_type prefix, input logic [BYTE_BITS-1:0] b);
      logic [31:0] key;
      logic [31:0] prod;
      logic [31:0] mixed;
      key   = (32'(prefix) << 8) | 32'(b);
      prod  = key * HASH_MULT;
      mixed = prod >> HASH_SHIFT;
      return int'(mixed % HASH_SLOTS);
   endfunction

   task automatic lzw_predict(input logic [BYTE_BITS-1:0] b, input logic eos,
                              output int n, output code_item_type res [2]);
      int                    s;
      int                    free_slot;
      bit                    hit;
      code_type              found;
      logic [LIMIT_BITS-1:0] cap;
      n      = 0;
      res[0] = '0;
      res[1] = '0;
      if (!match_open) begin
         match_code = code_type'(b);
         match_open = 1'b1;
      end else begin
         hit       = 1'b0;
         found     = '0;
         free_slot = HASH_SLOTS;
         s         = home_slot(match_code, b);
         for (int k = 0; k < HASH_SLOTS; k++) begin
            if (!slot_used[s]) begin
               free_slot = s;
               break;
            end
            if (slot_prefix[s] == match_code && slot_byte[s] == b) begin
               hit   = 1'b1;
               found = slot_code[s];
               break;
            end
            s = (s + 1) % HASH_SLOTS;
         end
         if (hit) begin
            match_code = found;
         end else begin
            res[0] = '{match_code, 1'b0};
            n      = 1;
            // limits past the code space behave as the code space
            cap = (limit_reg < CODE_SPACE) ? limit_reg : LIMIT_BITS'(CODE_SPACE);
            if (next_free < cap && free_slot < HASH_SLOTS) begin
               slot_used[free_slot]   = 1'b1;
               slot_prefix[free_slot] = match_code;
               slot_byte[free_slot]   = b;
               slot_code[free_slot]   = code_type'(next_free);
               next_free++;
            end
            match_code = code_type'(b);
         end
      end
      if (eos) begin
         res[n] = '{match_code, 1'b1};
         n++;
         forget_dictionary();
      end
   endtask

   // checker and watchdog, all at the rising edge in one process
   always @(posedge clock) begin : check_codes
      int            n;
      code_item_type res [2];
      code_item_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            lzw_predict(req_if.data_byte, req_if.end_of_stream, n, res);
            if (offer_typed) begin
               n      = offer_typed_n;
               res[0] = offer_code_a;
               res[1] = offer_code_b;
            end
            for (int i = 0; i < n; i++) pending_codes.push_back(res[i]);
            items_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            codes_seen++;
            if (pending_codes.size() == 0) begin
               $error("code %0d (last %0b) arrived with nothing expected",
                      rsp_if.code, rsp_if.last_code);
               err_count++;
            end else begin
               want = pending_codes.pop_front();
               if (rsp_if.code !== want.code) begin
                  $error("code: expected %0d, actual %0d", want.code, rsp_if.code);
                  err_count++;
               end
               if (rsp_if.last_code !== want.last_code) begin
                  $error("last_code: expected %0b, actual %0b", want.last_code, rsp_if.last_code);
                  err_count++;
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $error("no item moved for %0d cycles, %0d codes outstanding",
                   quiet_cycles, pending_codes.size());
            $display("lzw_compressor_core regression: fail");
            $finish;
         end
      end
   end

   // receiver: random stalls, or one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_req = 1'b0;
            long_holds++;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
         end
      end
   end

   // returns just after the accepting edge, valid still high
   task automatic offer_byte(input logic [BYTE_BITS-1:0] b, input logic eos,
                             input logic typed, input int n,
                             input code_item_type ca, input code_item_type cb);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      offer_typed          = typed;
      offer_typed_n        = n;
      offer_code_a         = ca;
      offer_code_b         = cb;
      req_if.valid         <= 1'b1;
      req_if.data_byte     <= b;
      req_if.end_of_stream <= eos;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_codes.size() != 0) @(negedge clock);
   endtask

   // a byte that makes no code may still be in the pipe, so let it settle first
   task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
      wait_drained();
      while (!req_if.ready) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      limit_reg    = value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      limit_writes++;
   endtask

   function automatic logic [LIMIT_BITS-1:0] phase_limit(input int p);
      case (p)
         0:       return 13'd4096;
         1:       return 13'd257;
         2:       return 13'd8191;
         3:       return 13'd300;
         4:       return 13'd0;
         5:       return 13'd512;
         6:       return 13'd256;
         default: return LIMIT_BITS'($urandom_range(4096, 257));
      endcase
   endfunction

   // mostly narrow alphabets so the dictionary grows and matches get long
   task automatic send_stream(input bit pause_mid, inout int count);
      int                   len;
      int                   pick;
      int                   span;
      stream_mix_type       mix;
      logic [BYTE_BITS-1:0] base;
      logic [BYTE_BITS-1:0] b;
      if (pause_mid)
         len = $urandom_range(40, 20);
      else if ($urandom_range(7) == 0)
         len = $urandom_range(200, 60);
      else
         len = $urandom_range(40, 1);
      pick = $urandom_range(9);
      mix  = (pick < 7) ? MIX_NARROW : (pick < 9) ? MIX_FULL : MIX_RUN;
      base = BYTE_BITS'($urandom);
      span = $urandom_range(3, 1);
      for (int i = 0; i < len; i++) begin
         case (mix)
            MIX_NARROW: b = base + BYTE_BITS'($urandom_range(span));
            MIX_FULL:   b = BYTE_BITS'($urandom);
            default:    b = base;
         endcase
         if (pause_mid && i == len / 2) wait_drained();
         offer_byte(b, (i == len - 1), 1'b0, 0, '0, '0);
         count++;
      end
      streams_sent++;
   endtask

   initial begin
      int phase_items;
      bit first_stream;
      req_if.valid         = 1'b0;
      req_if.data_byte     = '0;
      req_if.end_of_stream = 1'b0;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      offer_typed          = 1'b0;
      sender_idle_pct      = 0;
      rcv_stall_pct        = 0;
      long_hold_req        = 1'b0;
      limit_reg            = DICT_LIMIT_RESET;
      forget_dictionary();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed table, first rows run on the reset limit
      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].kind == ROW_LIMIT)
            write_limit(DIRECTED[r].limit);
         else
            offer_byte(DIRECTED[r].data, DIRECTED[r].eos, DIRECTED[r].typed,
                       int'(DIRECTED[r].n_codes),
                       {DIRECTED[r].code_a, DIRECTED[r].last_a},
                       {DIRECTED[r].code_b, DIRECTED[r].last_b});
      end

      // random streams, one limit and one idling pattern per phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_limit(phase_limit(p));
         case (p % 4)
            0:       begin sender_idle_pct = 0;  rcv_stall_pct = 0;  end
            1:       begin sender_idle_pct = 51; rcv_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  rcv_stall_pct = 51; end
            default: begin sender_idle_pct = 15; rcv_stall_pct = 15; end
         endcase
         // with no learning each byte past a stream's first gives a code; the hold-off fills the block quickly
         if (p == 4) long_hold_req = 1'b1;
         phase_items  = 0;
         first_stream = 1'b1;
         while (phase_items < PHASE_ITEMS) begin
            send_stream(p == 5 && first_stream, phase_items);
            first_stream = 1'b0;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_codes.size() != 0) begin
         $error("%0d expected codes never arrived", pending_codes.size());
         err_count++;
      end
      $display("covered %0d bytes in %0d random streams plus the directed table, %0d codes checked",
               items_taken, streams_sent, codes_seen);
      $display("%0d dictionary limit writes from 0 to 8191, %0d long output hold-offs",
               limit_writes, long_holds);
      if (err_count == 0)
         $display("lzw_compressor_core regression: pass");
      else
         $display("lzw_compressor_core regression: fail");
      $finish;
   end

endmodule
